>>> rtl/krte_pkg.sv
// ----------------------------------------------------------------------------
// krte_pkg
// Shared types and constants of the keyed record table engine.
// ----------------------------------------------------------------------------
package krte_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam logic [8:0]  INIT_SIZE_RST   = 9'd4;
  localparam logic [8:0]  APPEND_SIZE_RST = 9'd4;
  localparam int unsigned IN_TDATA_W      = 56;
  localparam int unsigned OUT_TDATA_W     = 72;

  // configuration register indexes
  localparam logic CFG_INITIAL_SIZE = 1'b0;
  localparam logic CFG_APPEND_SIZE  = 1'b1;

  typedef enum logic [2:0] {
    ACT_INIT   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_MODIFY = 3'd3,
    ACT_FIND   = 3'd4,
    ACT_SORT   = 3'd5,
    ACT_CLEAR  = 3'd6,
    ACT_NOP    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    RS_OK   = 2'd0,
    RS_FAIL = 2'd1,
    RS_ZERO = 2'd2
  } res_status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_CLEAR,
    OP_ZERO,
    OP_FAIL,
    OP_SRCH_START,
    OP_LIN_RD,
    OP_LIN_CMP,
    OP_BIN_RD,
    OP_BIN_CMP,
    OP_ADD,
    OP_MOD,
    OP_FIND_END,
    OP_RM_RD,
    OP_RM_WR,
    OP_RM_FIN,
    OP_SORT_START,
    OP_SORT_N,
    OP_SORT_X,
    OP_SORT_RD,
    OP_SORT_PUT,
    OP_SORT_CMP,
    OP_SORT_FIN,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_GO,
    S_LIN_RD,
    S_LIN_CMP,
    S_BIN_RD,
    S_BIN_CMP,
    S_SRCH_END,
    S_RM_WR,
    S_SORT_N,
    S_SORT_X,
    S_SORT_RD,
    S_SORT_CMP,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } krte_cmd_t;

  typedef struct packed {
    action_e act;
    logic    zero_fld;
    logic    sorted;
    logic    lin_end;
    logic    bin_end;
    logic    key_eq;
    logic    at_hi;
    logic    hit;
    logic    full;
    logic    moved;
    logic    sort_end;
    logic    i_zero;
    logic    less;
    logic    out_free;
  } krte_stat_t;

endpackage

>>> rtl/krte_ctrl.sv
// ----------------------------------------------------------------------------
// krte_ctrl
// Command sequencer: walks each action through search, update, sort and
// result steps, issuing one datapath command per cycle unless stalled on output.
// ----------------------------------------------------------------------------
module krte_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_beat_i,
  input  krte_pkg::krte_stat_t stat_i,
  output krte_pkg::krte_cmd_t  cmd_o,
  output logic                idle_o
);

  krte_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= krte_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      krte_pkg::S_IDLE: begin
        if (in_beat_i) state_d = krte_pkg::S_DECODE;
      end
      krte_pkg::S_DECODE: begin
        case (stat_i.act)
          krte_pkg::ACT_ADD, krte_pkg::ACT_MODIFY: begin
            state_d = stat_i.zero_fld ? krte_pkg::S_EMIT : krte_pkg::S_SRCH_GO;
          end
          krte_pkg::ACT_REMOVE, krte_pkg::ACT_FIND: state_d = krte_pkg::S_SRCH_GO;
          krte_pkg::ACT_SORT: state_d = krte_pkg::S_SORT_N;
          default: state_d = krte_pkg::S_EMIT;
        endcase
      end
      krte_pkg::S_SRCH_GO: begin
        state_d = stat_i.sorted ? krte_pkg::S_BIN_RD : krte_pkg::S_LIN_RD;
      end
      krte_pkg::S_LIN_RD: begin
        state_d = stat_i.lin_end ? krte_pkg::S_SRCH_END : krte_pkg::S_LIN_CMP;
      end
      krte_pkg::S_LIN_CMP: begin
        state_d = stat_i.key_eq ? krte_pkg::S_SRCH_END : krte_pkg::S_LIN_RD;
      end
      krte_pkg::S_BIN_RD: begin
        state_d = stat_i.bin_end ? krte_pkg::S_SRCH_END : krte_pkg::S_BIN_CMP;
      end
      krte_pkg::S_BIN_CMP: begin
        state_d = (stat_i.key_eq || stat_i.at_hi) ? krte_pkg::S_SRCH_END
                                                  : krte_pkg::S_BIN_RD;
      end
      krte_pkg::S_SRCH_END: begin
        if (stat_i.act == krte_pkg::ACT_REMOVE && stat_i.hit && stat_i.moved) begin
          state_d = krte_pkg::S_RM_WR;
        end else begin
          state_d = krte_pkg::S_EMIT;
        end
      end
      krte_pkg::S_RM_WR: state_d = krte_pkg::S_EMIT;
      krte_pkg::S_SORT_N: begin
        state_d = stat_i.sort_end ? krte_pkg::S_EMIT : krte_pkg::S_SORT_X;
      end
      krte_pkg::S_SORT_X: state_d = krte_pkg::S_SORT_RD;
      krte_pkg::S_SORT_RD: begin
        state_d = stat_i.i_zero ? krte_pkg::S_SORT_N : krte_pkg::S_SORT_CMP;
      end
      krte_pkg::S_SORT_CMP: begin
        state_d = stat_i.less ? krte_pkg::S_SORT_RD : krte_pkg::S_SORT_N;
      end
      krte_pkg::S_EMIT: begin
        if (stat_i.out_free) state_d = krte_pkg::S_IDLE;
      end
      default: state_d = krte_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o.op = krte_pkg::OP_NONE;
    idle_o   = 1'b0;
    case (state_q)
      krte_pkg::S_IDLE: begin
        idle_o = 1'b1;
        if (in_beat_i) cmd_o.op = krte_pkg::OP_LOAD;
      end
      krte_pkg::S_DECODE: begin
        case (stat_i.act)
          krte_pkg::ACT_INIT:  cmd_o.op = krte_pkg::OP_INIT;
          krte_pkg::ACT_CLEAR: cmd_o.op = krte_pkg::OP_CLEAR;
          krte_pkg::ACT_SORT:  cmd_o.op = krte_pkg::OP_SORT_START;
          krte_pkg::ACT_ADD, krte_pkg::ACT_MODIFY: begin
            cmd_o.op = stat_i.zero_fld ? krte_pkg::OP_ZERO : krte_pkg::OP_NONE;
          end
          default: cmd_o.op = krte_pkg::OP_NONE;
        endcase
      end
      krte_pkg::S_SRCH_GO: cmd_o.op = krte_pkg::OP_SRCH_START;
      krte_pkg::S_LIN_RD: begin
        if (!stat_i.lin_end) cmd_o.op = krte_pkg::OP_LIN_RD;
      end
      krte_pkg::S_LIN_CMP: cmd_o.op = krte_pkg::OP_LIN_CMP;
      krte_pkg::S_BIN_RD: begin
        if (!stat_i.bin_end) cmd_o.op = krte_pkg::OP_BIN_RD;
      end
      krte_pkg::S_BIN_CMP: cmd_o.op = krte_pkg::OP_BIN_CMP;
      krte_pkg::S_SRCH_END: begin
        case (stat_i.act)
          krte_pkg::ACT_ADD: begin
            cmd_o.op = (stat_i.hit || stat_i.full) ? krte_pkg::OP_FAIL : krte_pkg::OP_ADD;
          end
          krte_pkg::ACT_REMOVE: begin
            if (!stat_i.hit)       cmd_o.op = krte_pkg::OP_FAIL;
            else if (stat_i.moved) cmd_o.op = krte_pkg::OP_RM_RD;
            else                   cmd_o.op = krte_pkg::OP_RM_FIN;
          end
          krte_pkg::ACT_MODIFY: begin
            cmd_o.op = stat_i.hit ? krte_pkg::OP_MOD : krte_pkg::OP_FAIL;
          end
          default: cmd_o.op = krte_pkg::OP_FIND_END;
        endcase
      end
      krte_pkg::S_RM_WR: cmd_o.op = krte_pkg::OP_RM_WR;
      krte_pkg::S_SORT_N: begin
        cmd_o.op = stat_i.sort_end ? krte_pkg::OP_SORT_FIN : krte_pkg::OP_SORT_N;
      end
      krte_pkg::S_SORT_X: cmd_o.op = krte_pkg::OP_SORT_X;
      krte_pkg::S_SORT_RD: begin
        cmd_o.op = stat_i.i_zero ? krte_pkg::OP_SORT_PUT : krte_pkg::OP_SORT_RD;
      end
      krte_pkg::S_SORT_CMP: cmd_o.op = krte_pkg::OP_SORT_CMP;
      krte_pkg::S_EMIT: begin
        if (stat_i.out_free) cmd_o.op = krte_pkg::OP_EMIT;
      end
      default: cmd_o.op = krte_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/krte_datapath.sv
// ----------------------------------------------------------------------------
// krte_datapath
// Record memory, table state, search and sort registers, and the result
// register, all stepped by commands from the sequencer.
// ----------------------------------------------------------------------------
module krte_datapath #(
  parameter int unsigned MaxEntries = krte_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  krte_pkg::krte_cmd_t                  cmd_i,
  output krte_pkg::krte_stat_t                 stat_o,
  input  logic [krte_pkg::IN_TDATA_W-1:0]      in_data_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [8:0]                           cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [krte_pkg::OUT_TDATA_W-1:0]     out_data_o
);

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned VW = $clog2(MaxEntries + 1);
  localparam int unsigned EW = (VW > 17) ? VW + 1 : 18;

  // record memory: key in the upper word, count in the lower
  logic [47:0] mem_q [MaxEntries];
  logic [47:0] rdata_q;
  logic        rd_en, wr_en;
  logic [AW-1:0] raddr, waddr;
  logic [47:0] wdata;

  krte_pkg::action_e     act_q, act_d;
  krte_pkg::res_status_e rs_q, rs_d;
  logic [31:0]       key_q, key_d, xkey_q, xkey_d;
  logic [15:0]       cnt_q, cnt_d, xcnt_q, xcnt_d, hcnt_q, hcnt_d;
  logic [15:0]       cmp_q, cmp_d, fcnt_q, fcnt_d, alloc_q, alloc_d;
  logic [VW-1:0]     valid_q, valid_d, idx_q, idx_d, n_q, n_d, i_q, i_d;
  logic signed [VW:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [AW-1:0]     slot_q, slot_d;
  logic [7:0]        fslot_q, fslot_d;
  logic [8:0]        init_q, init_d, app_q, app_d;
  logic              sorted_q, sorted_d, hit_q, hit_d, ovalid_q, ovalid_d;
  logic [krte_pkg::OUT_TDATA_W-1:0] out_q, out_d;

  logic [31:0]        rd_key;
  logic [15:0]        rd_cnt;
  logic signed [VW:0] diff, mid_c;
  logic [EW-1:0]      alloc_e, valid_e, app_e, grow_sum, vlast_e;
  logic               grow_ok, fits, shrink;
  logic [15:0]        alloc_add, cmp_out;
  logic [VW-1:0]      vlast, im1;
  logic [AW+7:0]      slot_x;

  function automatic logic [15:0] sat_inc(input logic [15:0] a, input logic [1:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {15'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  assign rd_key  = rdata_q[47:16];
  assign rd_cnt  = rdata_q[15:0];
  assign diff    = hi_q - lo_q;
  assign mid_c   = lo_q + (diff >>> 1);
  assign alloc_e = EW'(alloc_q);
  assign valid_e = EW'(valid_q);
  assign app_e   = EW'(app_q);
  assign grow_sum  = alloc_e + app_e;
  assign grow_ok   = (alloc_e <= valid_e) && (grow_sum != '0);
  assign alloc_add = !grow_ok ? alloc_q :
                     (grow_sum > EW'(16'hFFFF)) ? 16'hFFFF : grow_sum[15:0];
  assign fits    = valid_e < EW'(alloc_add);
  assign vlast   = valid_q - VW'(1);
  assign vlast_e = EW'(vlast);
  assign shrink  = (alloc_e > app_e) && (alloc_e >= vlast_e + app_e);
  assign im1     = i_q - VW'(1);
  assign slot_x  = {8'd0, slot_q};
  assign cmp_out = (act_q == krte_pkg::ACT_FIND || act_q == krte_pkg::ACT_SORT)
                   ? cmp_q : 16'd0;

  always_comb begin
    stat_o.act      = act_q;
    stat_o.zero_fld = (key_q == '0) || (cnt_q == '0);
    stat_o.sorted   = sorted_q;
    stat_o.lin_end  = idx_q == valid_q;
    stat_o.bin_end  = diff < 0;
    stat_o.key_eq   = rd_key == key_q;
    stat_o.at_hi    = mid_q == hi_q;
    stat_o.hit      = hit_q;
    stat_o.full     = valid_q == VW'(MaxEntries);
    stat_o.moved    = VW'(slot_q) != vlast;
    stat_o.sort_end = n_q >= valid_q;
    stat_o.i_zero   = i_q == '0;
    stat_o.less     = xkey_q < rd_key;
    stat_o.out_free = !ovalid_q || out_ready_i;
  end

  // memory port addressing
  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = '0;
    wdata = {key_q, cnt_q};
    case (cmd_i.op)
      krte_pkg::OP_LIN_RD:  begin rd_en = 1'b1; raddr = idx_q[AW-1:0]; end
      krte_pkg::OP_BIN_RD:  begin rd_en = 1'b1; raddr = mid_c[AW-1:0]; end
      krte_pkg::OP_RM_RD:   begin rd_en = 1'b1; raddr = vlast[AW-1:0]; end
      krte_pkg::OP_SORT_N:  begin rd_en = 1'b1; raddr = n_q[AW-1:0]; end
      krte_pkg::OP_SORT_RD: begin rd_en = 1'b1; raddr = im1[AW-1:0]; end
      krte_pkg::OP_ADD: begin
        wr_en = fits;
        waddr = valid_q[AW-1:0];
      end
      krte_pkg::OP_MOD: begin
        wr_en = 1'b1;
        waddr = slot_q;
      end
      krte_pkg::OP_RM_WR: begin
        wr_en = 1'b1;
        waddr = slot_q;
        wdata = rdata_q;
      end
      krte_pkg::OP_SORT_PUT: begin
        wr_en = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = {xkey_q, xcnt_q};
      end
      krte_pkg::OP_SORT_CMP: begin
        wr_en = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = (xkey_q < rd_key) ? rdata_q : {xkey_q, xcnt_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= wdata;
    if (rd_en) rdata_q <= mem_q[raddr];
  end

  always_comb begin
    act_d = act_q;   rs_d = rs_q;     key_d = key_q;   cnt_d = cnt_q;
    xkey_d = xkey_q; xcnt_d = xcnt_q; hcnt_d = hcnt_q; cmp_d = cmp_q;
    fcnt_d = fcnt_q; alloc_d = alloc_q; valid_d = valid_q; idx_d = idx_q;
    n_d = n_q;       i_d = i_q;       lo_d = lo_q;     hi_d = hi_q;
    mid_d = mid_q;   slot_d = slot_q; fslot_d = fslot_q; init_d = init_q;
    app_d = app_q;   sorted_d = sorted_q; hit_d = hit_q; out_d = out_q;
    ovalid_d = ovalid_q && !out_ready_i;

    if (cfg_we_i) begin
      if (cfg_idx_i == krte_pkg::CFG_INITIAL_SIZE) init_d = cfg_data_i;
      else                                         app_d  = cfg_data_i;
    end

    case (cmd_i.op)
      krte_pkg::OP_LOAD: begin
        act_d   = krte_pkg::action_e'(in_data_i[2:0]);
        key_d   = in_data_i[34:3];
        cnt_d   = in_data_i[50:35];
        rs_d    = krte_pkg::RS_OK;
        fslot_d = '0;
        fcnt_d  = '0;
        cmp_d   = '0;
      end
      krte_pkg::OP_INIT: begin
        valid_d  = '0;
        sorted_d = 1'b0;
        alloc_d  = {7'd0, init_q};
      end
      krte_pkg::OP_CLEAR: begin
        valid_d = '0;
        alloc_d = '0;
      end
      krte_pkg::OP_ZERO: rs_d = krte_pkg::RS_ZERO;
      krte_pkg::OP_FAIL: rs_d = krte_pkg::RS_FAIL;
      krte_pkg::OP_SRCH_START: begin
        idx_d  = '0;
        lo_d   = '0;
        hi_d   = $signed({1'b0, valid_q}) - $signed((VW+1)'(1));
        hit_d  = 1'b0;
        cmp_d  = '0;
        slot_d = '0;
      end
      krte_pkg::OP_LIN_CMP: begin
        cmp_d = sat_inc(cmp_q, 2'd1);
        if (rd_key == key_q) begin
          hit_d  = 1'b1;
          slot_d = idx_q[AW-1:0];
          hcnt_d = rd_cnt;
        end else begin
          idx_d = idx_q + VW'(1);
        end
      end
      krte_pkg::OP_BIN_RD: mid_d = mid_c;
      krte_pkg::OP_BIN_CMP: begin
        if (rd_key == key_q) begin
          cmp_d  = sat_inc(cmp_q, 2'd1);
          hit_d  = 1'b1;
          slot_d = mid_q[AW-1:0];
          hcnt_d = rd_cnt;
        end else if (mid_q != hi_q) begin
          cmp_d = sat_inc(cmp_q, 2'd2);
          if (rd_key > key_q) hi_d = mid_q - $signed((VW+1)'(1));
          else                lo_d = mid_q + $signed((VW+1)'(1));
        end
      end
      krte_pkg::OP_ADD: begin
        alloc_d = alloc_add;
        if (fits) begin
          valid_d  = valid_q + VW'(1);
          sorted_d = 1'b0;
        end else begin
          rs_d = krte_pkg::RS_FAIL;
        end
      end
      krte_pkg::OP_MOD: begin
        fslot_d = slot_x[7:0];
        fcnt_d  = cnt_q;
      end
      krte_pkg::OP_FIND_END: begin
        if (hit_q) begin
          fslot_d = slot_x[7:0];
          fcnt_d  = hcnt_q;
        end else begin
          rs_d = krte_pkg::RS_FAIL;
        end
      end
      krte_pkg::OP_RM_WR, krte_pkg::OP_RM_FIN: begin
        if (cmd_i.op == krte_pkg::OP_RM_WR) sorted_d = 1'b0;
        valid_d = vlast;
        if (shrink) alloc_d = alloc_q - {7'd0, app_q};
      end
      krte_pkg::OP_SORT_START: begin
        n_d   = VW'(1);
        cmp_d = '0;
      end
      krte_pkg::OP_SORT_X: begin
        xkey_d = rd_key;
        xcnt_d = rd_cnt;
        i_d    = n_q;
      end
      krte_pkg::OP_SORT_PUT: n_d = n_q + VW'(1);
      krte_pkg::OP_SORT_CMP: begin
        cmp_d = sat_inc(cmp_q, 2'd1);
        if (xkey_q < rd_key) i_d = im1;
        else                 n_d = n_q + VW'(1);
      end
      krte_pkg::OP_SORT_FIN: sorted_d = 1'b1;
      krte_pkg::OP_EMIT: begin
        out_d    = {5'd0, alloc_q, valid_e[8:0], cmp_out, fcnt_q, fslot_q, rs_q};
        ovalid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      sorted_q <= 1'b0;
      alloc_q  <= {7'd0, krte_pkg::INIT_SIZE_RST};
      init_q   <= krte_pkg::INIT_SIZE_RST;
      app_q    <= krte_pkg::APPEND_SIZE_RST;
      ovalid_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      sorted_q <= sorted_d;
      alloc_q  <= alloc_d;
      init_q   <= init_d;
      app_q    <= app_d;
      ovalid_q <= ovalid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    act_q <= act_d;   rs_q <= rs_d;     key_q <= key_d;   cnt_q <= cnt_d;
    xkey_q <= xkey_d; xcnt_q <= xcnt_d; hcnt_q <= hcnt_d; cmp_q <= cmp_d;
    fcnt_q <= fcnt_d; idx_q <= idx_d;   n_q <= n_d;       i_q <= i_d;
    lo_q <= lo_d;     hi_q <= hi_d;     mid_q <= mid_d;   slot_q <= slot_d;
    fslot_q <= fslot_d; hit_q <= hit_d; out_q <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/keyed_record_table_engine_top.sv
// ----------------------------------------------------------------------------
// keyed_record_table_engine_top
// Keyed record table: init, clear, add, remove, modify, find (linear or
// binary) and an insertion sort over one record memory.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    action, student_key, fail_count
//  m_*       out  m_tvalid / m_tready    status .. alloc_size
//  cfg_*     in   cfg_we_i (no wait)     initial_size (0), append_size (1)
//
//  One beat per action. Init, clear and zero-field rejects skip the search;
//  an unsorted search reads and compares each entry scanned, a binary
//  search each probe, and the sort each comparison plus a read per pass
//  (and a store when the record moves to the front), all set by the single
//  read port of the record memory.
//  Reset clears the table counters and restores the registers; the record
//  memory is not cleared. A result waiting on m_tready does not block the
//  next beat from being taken; only the final hand-off stalls.
// ----------------------------------------------------------------------------
module keyed_record_table_engine_top #(
  parameter int unsigned MaxEntries = krte_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // action[2:0], student_key[34:3], fail_count[50:35], zero fill
  input  logic [krte_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // status[1:0], found_slot[9:2], found_count[25:10], comparisons[41:26],
  // entry_count[50:42], alloc_size[66:51], zero fill
  output logic [krte_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [8:0]                       cfg_data_i
);

  krte_pkg::krte_cmd_t  cmd;
  krte_pkg::krte_stat_t stat;
  logic                 idle;

  assign s_tready = idle;

  krte_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_beat_i (s_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  krte_datapath #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata)
  );

endmodule

>>> rtl/krte_checker.sv
// ----------------------------------------------------------------------------
// krte_checker
// Port-level checks of the keyed record table engine.
// ----------------------------------------------------------------------------
module krte_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [krte_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // a held result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one action at a time: no second beat straight after a taken one
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready |=> !s_tready)
    else $error("beat taken while busy");

  // no status code beyond zero-field
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("bad status code");

  // a zero-field reject reports no hit and no comparisons
  a_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tdata[1:0] == 2'd2 |-> m_tdata[41:2] == '0)
    else $error("zero-field reject with payload");

endmodule

bind keyed_record_table_engine_top krte_checker u_krte_checker (.*);
